FILE: sv/sample_loop_address_generator_core_macros.svh
// Assertion macros shared by the sample loop address generator RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef SAMPLE_LOOP_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define SAMPLE_LOOP_ADDRESS_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLAG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/slag_pkg.sv
// Package for the sample loop address generator: widths, codes and shared structs.
// No dependencies; every other file except the assertion macros header imports it.
`timescale 1ns / 1ps

package slag_pkg;

  localparam int SLAG_MAX_BURST = 16;

  localparam int FRAME_W    = 31;
  localparam int OFFSET_W   = 32;
  localparam int BPF_W      = 4;
  localparam int ADDR_W     = 33;
  localparam int REQ_W      = 2;
  localparam int COUNT_W    = 5;
  localparam int SEEK_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [BPF_W-1:0] BPF_RESET = BPF_W'(2);

  typedef enum logic [REQ_W-1:0] {
    REQ_FETCH   = 2'd0,
    REQ_SEEK    = 2'd1,
    REQ_RESTART = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_FRAMES    = 3'd0,
    CFG_IN_POINT        = 3'd1,
    CFG_OUT_POINT       = 3'd2,
    CFG_LOOP_ENABLE     = 3'd3,
    CFG_LOOP_START      = 3'd4,
    CFG_LOOP_END        = 3'd5,
    CFG_DATA_OFFSET     = 3'd6,
    CFG_BYTES_PER_FRAME = 3'd7
  } cfg_reg_t;

  // Resolved playback region, handed from the register block to the generator.
  typedef struct packed {
    logic [FRAME_W-1:0] total;
    logic [FRAME_W-1:0] restart_pos;
    logic [FRAME_W-1:0] wrap_start;
    logic [FRAME_W-1:0] wrap_end;
    logic [FRAME_W-1:0] wrap_end_m1;
    logic               wrap_ok;
    logic               start_at_last;
    logic               busy;
  } slag_bounds_t;

  // One result before the byte address is formed.
  typedef struct packed {
    logic               frame_valid;
    logic [FRAME_W-1:0] frame_index;
    logic               wrapped;
    logic               last;
  } slag_frame_t;

endpackage

FILE: sv/slag_if.sv
// Channel interfaces of the sample loop address generator: request, result and config write.
// Depends on slag_pkg for field widths.
`timescale 1ns / 1ps

interface slag_req_if import slag_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [COUNT_W-1:0]       frame_count;
  logic signed [SEEK_W-1:0] seek_target;

  modport source (output valid, req_type, frame_count, seek_target, input ready);
  modport sink   (input valid, req_type, frame_count, seek_target, output ready);
endinterface

interface slag_res_if import slag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               frame_valid;
  logic [FRAME_W-1:0] frame_index;
  logic [ADDR_W-1:0]  byte_address;
  logic               wrapped;
  logic               last;

  modport source (output valid, frame_valid, frame_index, byte_address, wrapped, last,
                  input ready);
  modport sink   (input valid, frame_valid, frame_index, byte_address, wrapped, last,
                  output ready);
endinterface

interface slag_cfg_if import slag_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/slag_bounds.sv
// Configuration registers and the three-stage resolution of trim and loop bounds.
// Depends on slag_pkg and slag_cfg_if.
`timescale 1ns / 1ps

module slag_bounds import slag_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  slag_cfg_if.sink         cfg_wr,
  output slag_bounds_t     bounds,
  output logic [OFFSET_W-1:0] data_offset,
  output logic [BPF_W-1:0]    bytes_per_frame
);

  localparam int RESOLVE_STAGES = 3;
  localparam int BUSY_W = $clog2(RESOLVE_STAGES + 1);

  logic [FRAME_W-1:0]  total_r, in_point_r, out_point_r, lstart_r, lend_r;
  logic                loop_en_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [BPF_W-1:0]    bpf_r;
  logic [BUSY_W-1:0]   busy_r;

  // stage 1
  logic [FRAME_W-1:0] trim_end_r, ls_sel_r, le_sel_r, restart_r;
  logic [FRAME_W-1:0] trim_end_nxt, ls_sel_nxt, le_sel_nxt, restart_nxt;
  // stage 2
  logic [FRAME_W-1:0] ls_r, le_r, ls_nxt, le_nxt;
  logic               le_below;
  // stage 3
  logic [FRAME_W-1:0] le_m1_r;
  logic               wrap_ok_r, start_last_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      in_point_r   <= '0;
      out_point_r  <= '0;
      loop_en_r    <= 1'b0;
      lstart_r     <= '0;
      lend_r       <= '0;
      offset_r     <= '0;
      bpf_r        <= BPF_RESET;
      busy_r       <= BUSY_W'(RESOLVE_STAGES);
    end else begin
      if (cfg_wr.valid) begin
        busy_r <= BUSY_W'(RESOLVE_STAGES);
        case (cfg_reg_t'(cfg_wr.index))
          CFG_TOTAL_FRAMES:    total_r      <= cfg_wr.data[FRAME_W-1:0];
          CFG_IN_POINT:        in_point_r   <= cfg_wr.data[FRAME_W-1:0];
          CFG_OUT_POINT:       out_point_r  <= cfg_wr.data[FRAME_W-1:0];
          CFG_LOOP_ENABLE:     loop_en_r    <= cfg_wr.data[0];
          CFG_LOOP_START:      lstart_r     <= cfg_wr.data[FRAME_W-1:0];
          CFG_LOOP_END:        lend_r       <= cfg_wr.data[FRAME_W-1:0];
          CFG_DATA_OFFSET:     offset_r     <= cfg_wr.data[OFFSET_W-1:0];
          CFG_BYTES_PER_FRAME: bpf_r        <= cfg_wr.data[BPF_W-1:0];
          default: ;
        endcase
      end else if (busy_r != '0) begin
        busy_r <= busy_r - BUSY_W'(1);
      end
    end
  end

  // Stage 1: effective end, restart position and the raw loop points.
  always_comb begin
    trim_end_nxt = (out_point_r == '0 || out_point_r > total_r) ? total_r : out_point_r;
    ls_sel_nxt   = (loop_en_r && lstart_r != '0) ? lstart_r : in_point_r;
    le_sel_nxt   = (loop_en_r && lend_r != '0) ? lend_r : trim_end_nxt;
    restart_nxt  = (in_point_r > total_r) ? total_r : in_point_r;
  end

  // Stage 2: clamp loop start to the end, loop end to [start, end].
  always_comb begin
    ls_nxt   = (ls_sel_r > trim_end_r) ? trim_end_r : ls_sel_r;
    le_below = (ls_sel_r > trim_end_r) ? (le_sel_r < trim_end_r) : (le_sel_r < ls_sel_r);
    if (le_below) begin
      le_nxt = ls_nxt;
    end else begin
      le_nxt = (le_sel_r > trim_end_r) ? trim_end_r : le_sel_r;
    end
  end

  always_ff @(posedge clk) begin
    trim_end_r   <= trim_end_nxt;
    ls_sel_r     <= ls_sel_nxt;
    le_sel_r     <= le_sel_nxt;
    restart_r    <= restart_nxt;
    ls_r         <= ls_nxt;
    le_r         <= le_nxt;
    le_m1_r      <= le_r - FRAME_W'(1);
    wrap_ok_r    <= loop_en_r && (le_r > ls_r);
    start_last_r <= (FRAME_W'(ls_r + FRAME_W'(1)) == le_r);
  end

  always_comb begin
    bounds.total         = total_r;
    bounds.restart_pos   = restart_r;
    bounds.wrap_start    = ls_r;
    bounds.wrap_end      = le_r;
    bounds.wrap_end_m1   = le_m1_r;
    bounds.wrap_ok       = wrap_ok_r;
    bounds.start_at_last = start_last_r;
    bounds.busy          = (busy_r != '0);
  end

  assign data_offset     = offset_r;
  assign bytes_per_frame = bpf_r;

endmodule

FILE: sv/slag_gen.sv
// Request reg and frame sequencer: one result per cycle unless stalled, wrap check per frame.
// Depends on slag_pkg, slag_req_if and the assertion macros header.
`timescale 1ns / 1ps

`include "sample_loop_address_generator_core_macros.svh"

module slag_gen import slag_pkg::*; #(
  parameter int MAX_BURST = SLAG_MAX_BURST
) (
  input  logic         clk,
  input  logic         rst_n,
  slag_req_if.sink     in_req,
  input  slag_bounds_t bounds,
  output logic         res_valid,
  input  logic         res_ready,
  output slag_frame_t  res
);

  localparam int CNT_W = $clog2(MAX_BURST + 1);

  typedef enum logic {GEN_IDLE, GEN_RUN} gen_state_t;

  gen_state_t          state_r, state_nxt;
  logic                in_valid_r, in_valid_nxt;
  logic [REQ_W-1:0]    req_r;
  logic [CNT_W-1:0]    want_r, want_c;
  logic [SEEK_W-1:0]   seek_r;
  logic [FRAME_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt, cur_rem;
  logic                res_valid_r, res_valid_nxt;
  slag_frame_t         res_r, res_nxt, frame_c;

  logic               in_take, stage_free, fire_idle, fire_run;
  logic               need_wrap, hit_end, last_frame, no_frame;
  logic [FRAME_W-1:0] emit_idx, seek_pos;

  // Saturate the burst length as the request enters.
  assign want_c = (int'(in_req.frame_count) > MAX_BURST) ? CNT_W'(MAX_BURST)
                                                         : CNT_W'(in_req.frame_count);

  assign stage_free   = !res_valid_r || res_ready;
  assign fire_idle    = (state_r == GEN_IDLE) && in_valid_r && !bounds.busy && stage_free;
  assign fire_run     = (state_r == GEN_RUN) && stage_free;
  assign in_req.ready = !in_valid_r || fire_idle;
  assign in_take      = in_req.valid && in_req.ready;
  assign in_valid_nxt = in_take || (in_valid_r && !fire_idle);

  // Wrap check for the frame at the play position.
  always_comb begin
    need_wrap  = (pos_r >= bounds.wrap_end);
    emit_idx   = need_wrap ? bounds.wrap_start : pos_r;
    hit_end    = need_wrap ? bounds.start_at_last : (pos_r == bounds.wrap_end_m1);
    cur_rem    = (state_r == GEN_RUN) ? rem_r : want_r;
    last_frame = (cur_rem == CNT_W'(1)) || (hit_end && !bounds.wrap_ok);
    no_frame   = (want_r == '0) || (need_wrap && !bounds.wrap_ok);
    seek_pos   = seek_r[SEEK_W-1] ? '0 :
                 ((seek_r[FRAME_W-1:0] > bounds.total) ? bounds.total : seek_r[FRAME_W-1:0]);

    frame_c.frame_valid = 1'b1;
    frame_c.frame_index = emit_idx;
    frame_c.wrapped     = need_wrap;
    frame_c.last        = last_frame;
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    case (state_r)
      GEN_IDLE: begin
        if (fire_idle) begin
          res_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.last  = 1'b1;
          case (req_type_t'(req_r))
            REQ_FETCH: begin
              if (!no_frame) begin
                res_nxt = frame_c;
                pos_nxt = emit_idx + FRAME_W'(1);
                if (!last_frame) begin
                  state_nxt = GEN_RUN;
                  rem_nxt   = cur_rem - CNT_W'(1);
                end
              end
            end
            REQ_SEEK:    pos_nxt = seek_pos;
            REQ_RESTART: pos_nxt = bounds.restart_pos;
            default: ;
          endcase
        end
      end
      GEN_RUN: begin
        if (fire_run) begin
          res_valid_nxt = 1'b1;
          res_nxt       = frame_c;
          pos_nxt       = emit_idx + FRAME_W'(1);
          rem_nxt       = rem_r - CNT_W'(1);
          if (last_frame) begin
            state_nxt = GEN_IDLE;
          end
        end
      end
      default: state_nxt = GEN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= GEN_IDLE;
      in_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      pos_r       <= '0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      in_valid_r  <= in_valid_nxt;
      res_valid_r <= res_valid_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
    end
    res_r <= res_nxt;
    if (in_take) begin
      req_r  <= in_req.req_type;
      want_r <= want_c;
      seek_r <= in_req.seek_target;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `SLAG_ASSERT_IMPL(a_run_has_frames, state_r == GEN_RUN, rem_r != '0, "burst running with nothing left")
  `SLAG_ASSERT_IMPL(a_blank_is_last, res_valid_r && !res_r.frame_valid, res_r.last && res_r.frame_index == '0 && !res_r.wrapped, "frameless result not blank and last")
  `SLAG_ASSERT_NEXT(a_res_held, res_valid_r && !res_ready, res_valid_r && $stable(res_r), "stalled result changed")
  `SLAG_ASSERT_NEXT(a_run_only_fetch, fire_idle && req_r != REQ_FETCH, state_r == GEN_IDLE, "non-fetch request started a burst")

endmodule

FILE: sv/slag_addr.sv
// Byte address stage and output register: offset plus frame index times frame size.
// Depends on slag_pkg, slag_res_if and the assertion macros header.
`timescale 1ns / 1ps

`include "sample_loop_address_generator_core_macros.svh"

module slag_addr import slag_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  output logic                res_ready,
  input  slag_frame_t         res,
  input  logic [OFFSET_W-1:0] data_offset,
  input  logic [BPF_W-1:0]    bytes_per_frame,
  slag_res_if.source          out_res
);

  logic                     out_valid_r;
  slag_frame_t              frame_r;
  logic [ADDR_W-1:0]        addr_r, addr_c;
  logic [FRAME_W+BPF_W-1:0] prod;
  logic                     take;

  assign res_ready = !out_valid_r || out_res.ready;
  assign take      = res_valid && res_ready;

  // Frameless results carry a zero address, not the data offset.
  always_comb begin
    prod   = res.frame_index * bytes_per_frame;
    addr_c = res.frame_valid ? (ADDR_W'(prod) + ADDR_W'(data_offset)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (take) begin
      frame_r <= res;
      addr_r  <= addr_c;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.frame_valid  = frame_r.frame_valid;
  assign out_res.frame_index  = frame_r.frame_index;
  assign out_res.byte_address = addr_r;
  assign out_res.wrapped      = frame_r.wrapped;
  assign out_res.last         = frame_r.last;

  `SLAG_ASSERT_IMPL(a_blank_addr, out_valid_r && !frame_r.frame_valid, addr_r == '0, "frameless result with non-zero address")

endmodule

FILE: sv/sample_loop_address_generator_core.sv
// Sample loop address generator top level: registers, bound resolution, sequencer, address stage.
// A request passes the request register, the sequencer result register and the output register.
// Throughput: one result per cycle while the output does not stall; a seek, restart or illegal
// request gives one result. After a config write the sequencer waits until the bounds are resolved.
// Reset (rst_n low, synchronous): registers to defaults, play position 0, channels empty.
`timescale 1ns / 1ps

module sample_loop_address_generator_core import slag_pkg::*; #(
  parameter int MAX_BURST = SLAG_MAX_BURST
) (
  input  logic       clk,
  input  logic       rst_n,
  slag_req_if.sink   in_req,
  slag_res_if.source out_res,
  slag_cfg_if.sink   cfg_wr
);

  // Resolved bounds; busy while a new register value ripples through resolution.
  slag_bounds_t        bounds;
  logic [OFFSET_W-1:0] data_offset;
  logic [BPF_W-1:0]    bytes_per_frame;

  // Sequencer to address stage: one frame result per transaction.
  logic        res_valid;
  logic        res_ready;
  slag_frame_t res;

  // Hold the config registers and resolve end, loop start and loop end in three stages.
  slag_bounds u_bounds (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr          (cfg_wr),
    .bounds          (bounds),
    .data_offset     (data_offset),
    .bytes_per_frame (bytes_per_frame)
  );

  // Register the request, then advance the play position one frame per cycle unless stalled,
  // wrapping to loop start at loop end, or drop out early when no wrap is allowed.
  slag_gen #(
    .MAX_BURST (MAX_BURST)
  ) u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .bounds    (bounds),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Form the byte address and hold the result until the sink takes the transaction.
  slag_addr u_addr (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .data_offset     (data_offset),
    .bytes_per_frame (bytes_per_frame),
    .out_res         (out_res)
  );

endmodule

FILE: verif/slag_tracker_pkg.sv
// Playback tracker for the sample loop address generator testbench: register copy,
// play position and the queue of frame results still owed by the block. Uses slag_pkg.
`timescale 1ns / 1ps

package slag_tracker_pkg;
  import slag_pkg::*;

  localparam logic [REQ_W-1:0] REQ_ILLEGAL = 2'd3;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               frame_valid;
    logic [FRAME_W-1:0] frame_index;
    logic [ADDR_W-1:0]  byte_address;
    logic               wrapped;
    logic               last;
  } play_result_t;

  class loop_address_tracker;
    logic [FRAME_W-1:0]  total_frames;
    logic [FRAME_W-1:0]  in_point;
    logic [FRAME_W-1:0]  out_point;
    logic                loop_enable;
    logic [FRAME_W-1:0]  lstart_reg;
    logic [FRAME_W-1:0]  lend_reg;
    logic [OFFSET_W-1:0] data_offset;
    logic [BPF_W-1:0]    bytes_per_frame;
    logic [FRAME_W-1:0]  play_pos;
    play_result_t        pending_frames[$];
    int                  mismatches;

    function new();
      total_frames    = '0;
      in_point        = '0;
      out_point       = '0;
      loop_enable     = 1'b0;
      lstart_reg      = '0;
      lend_reg        = '0;
      data_offset     = '0;
      bytes_per_frame = BPF_RESET;
      play_pos        = '0;
      mismatches      = 0;
    endfunction

    function int pending();
      return pending_frames.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TOTAL_FRAMES:    total_frames    = data[FRAME_W-1:0];
        CFG_IN_POINT:        in_point        = data[FRAME_W-1:0];
        CFG_OUT_POINT:       out_point       = data[FRAME_W-1:0];
        CFG_LOOP_ENABLE:     loop_enable     = data[0];
        CFG_LOOP_START:      lstart_reg      = data[FRAME_W-1:0];
        CFG_LOOP_END:        lend_reg        = data[FRAME_W-1:0];
        CFG_DATA_OFFSET:     data_offset     = data[OFFSET_W-1:0];
        CFG_BYTES_PER_FRAME: bytes_per_frame = data[BPF_W-1:0];
        default: ;
      endcase
    endfunction

    // Effective end, loop start and loop end as seen by a fetch.
    function void resolve_region(output logic [FRAME_W-1:0] reg_end,
                                 output logic [FRAME_W-1:0] lp_start,
                                 output logic [FRAME_W-1:0] lp_end);
      reg_end = (out_point == 0 || out_point > total_frames) ? total_frames : out_point;
      lp_start = (loop_enable && lstart_reg != 0) ? lstart_reg : in_point;
      if (lp_start > reg_end) lp_start = reg_end;
      lp_end = (loop_enable && lend_reg != 0) ? lend_reg : reg_end;
      if (lp_end < lp_start) lp_end = lp_start;
      if (lp_end > reg_end) lp_end = reg_end;
    endfunction

    function void push_empty();
      play_result_t r;
      r = '0;
      r.last = 1'b1;
      pending_frames.push_back(r);
    endfunction

    function void note_request(logic [REQ_W-1:0] rt, logic [COUNT_W-1:0] cnt,
                               logic [SEEK_W-1:0] tgt);
      logic [FRAME_W-1:0] reg_end, lp_start, lp_end, pos;
      logic [63:0]        wide_addr;
      play_result_t       cur, prev;
      logic               have_prev, wrap_pend;
      int                 want, n;

      case (rt)
        REQ_SEEK: begin
          if (tgt[SEEK_W-1]) play_pos = '0;
          else if (tgt > {1'b0, total_frames}) play_pos = total_frames;
          else play_pos = tgt[FRAME_W-1:0];
          push_empty();
        end
        REQ_RESTART: begin
          play_pos = (in_point > total_frames) ? total_frames : in_point;
          push_empty();
        end
        REQ_FETCH: begin
          want = (cnt > SLAG_MAX_BURST) ? SLAG_MAX_BURST : int'(cnt);
          resolve_region(reg_end, lp_start, lp_end);
          pos = play_pos;
          n = 0;
          wrap_pend = 1'b0;
          have_prev = 1'b0;
          prev = '0;
          while (n < want) begin
            if (pos >= lp_end) begin
              // wrap only into a non-empty loop region, else cut the burst short
              if (loop_enable && lp_end > lp_start) begin
                pos = lp_start;
                wrap_pend = 1'b1;
                continue;
              end
              break;
            end
            wide_addr = 64'(data_offset) + 64'(pos) * 64'(bytes_per_frame);
            cur.frame_valid  = 1'b1;
            cur.frame_index  = pos;
            cur.byte_address = wide_addr[ADDR_W-1:0];
            cur.wrapped      = wrap_pend;
            cur.last         = 1'b0;
            // hold each frame back one step so the final one can take its last flag
            if (have_prev) pending_frames.push_back(prev);
            prev = cur;
            have_prev = 1'b1;
            wrap_pend = 1'b0;
            pos = pos + 1'b1;
            n++;
          end
          play_pos = pos;
          if (have_prev) begin
            prev.last = 1'b1;
            pending_frames.push_back(prev);
          end else begin
            push_empty();
          end
        end
        default: push_empty();
      endcase
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("MISMATCH: %s", what);
    endfunction

    function void check_frame(play_result_t got);
      play_result_t want;
      if (pending_frames.size() == 0) begin
        report($sformatf({"result with nothing outstanding: valid %0b index %0h",
                          " addr %0h wrapped %0b last %0b"},
                         got.frame_valid, got.frame_index, got.byte_address, got.wrapped,
                         got.last));
        return;
      end
      want = pending_frames.pop_front();
      if (got.frame_valid !== want.frame_valid || got.frame_index !== want.frame_index ||
          got.byte_address !== want.byte_address || got.wrapped !== want.wrapped ||
          got.last !== want.last)
        report($sformatf({"exp/act frame_valid %0b/%0b index %0h/%0h addr %0h/%0h",
                          " wrapped %0b/%0b last %0b/%0b"},
                         want.frame_valid, got.frame_valid, want.frame_index,
                         got.frame_index, want.byte_address, got.byte_address,
                         want.wrapped, got.wrapped, want.last, got.last));
    endfunction
  endclass

endpackage

FILE: verif/testbench.sv
// Testbench for sample_loop_address_generator_core: directed and random fetch, seek and
// restart traffic under random register settings, checked against slag_tracker_pkg.
// Depends on slag_pkg, slag_if.sv and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import slag_pkg::*;
  import slag_tracker_pkg::*;

  localparam int CYCLE_LIMIT  = 800_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 18;

  logic clk;
  logic rst_n;

  slag_req_if in_req();
  slag_res_if out_res();
  slag_cfg_if cfg_wr();

  sample_loop_address_generator_core #(.MAX_BURST(SLAG_MAX_BURST)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  loop_address_tracker tracker;
  logic                no_idle;   // phase without any gaps or stalls
  logic                req_held;  // in_req.valid is currently high
  logic                cfg_held;  // cfg_wr.valid is currently high
  int                  cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drop the request valid; call only at a clock edge.
  task automatic drop_req();
    if (req_held) begin
      in_req.valid <= 1'b0;
      req_held = 1'b0;
    end
  endtask

  task automatic drop_cfg();
    if (cfg_held) begin
      cfg_wr.valid <= 1'b0;
      cfg_held = 1'b0;
    end
  endtask

  // Offer one request transaction and hold it until the block takes it.
  // Valid stays high afterwards so that back-to-back requests need no extra edge.
  task automatic send_req(logic [REQ_W-1:0] rt, logic [COUNT_W-1:0] cnt,
                          logic [SEEK_W-1:0] tgt);
    int gap;
    gap = pick_gap();
    drop_cfg();
    if (gap > 0) begin
      drop_req();
      repeat (gap) @(posedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.req_type    <= rt;
    in_req.frame_count <= cnt;
    in_req.seek_target <= tgt;
    req_held = 1'b1;
    do @(posedge clk); while (!in_req.ready);
    tracker.note_request(rt, cnt, tgt);
  endtask

  // Pause the sender until every owed result has been taken.
  // The loop always waits on a clock edge first, so a dropped valid is never raised in the same step.
  task automatic wait_idle();
    drop_req();
    drop_cfg();
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // Write one register; only ever called once the block has drained.
  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    drop_req();
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    cfg_held = 1'b1;
    do @(posedge clk); while (!cfg_wr.ready);
    tracker.write_reg(idx, value);
  endtask

  task automatic cfg_all(logic [31:0] total, logic [31:0] in_pt, logic [31:0] out_pt,
                         logic [31:0] loop_en, logic [31:0] lp_start, logic [31:0] lp_end,
                         logic [31:0] offset, logic [31:0] bpf);
    wait_idle();
    cfg_write(CFG_TOTAL_FRAMES, total);
    cfg_write(CFG_IN_POINT, in_pt);
    cfg_write(CFG_OUT_POINT, out_pt);
    cfg_write(CFG_LOOP_ENABLE, loop_en);
    cfg_write(CFG_LOOP_START, lp_start);
    cfg_write(CFG_LOOP_END, lp_end);
    cfg_write(CFG_DATA_OFFSET, offset);
    cfg_write(CFG_BYTES_PER_FRAME, bpf);
  endtask

  // A frame point for the trim and loop registers: mostly inside the data,
  // sometimes zero, the very end, just past it, or anything at all.
  function automatic logic [31:0] pick_point(logic [FRAME_W-1:0] total);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    return 32'd0;
      2:       return {1'b0, total};
      3:       return 32'(total) + $urandom_range(1, 8);
      4:       return $urandom();
      default: return $urandom_range(0, total);
    endcase
  endfunction

  task automatic random_setting();
    logic [31:0]        total_w, en_w, offset_w, bpf_w;
    logic [FRAME_W-1:0] total;
    case ($urandom_range(0, 3))
      0:       total_w = $urandom_range(0, 40);
      1:       total_w = $urandom_range(41, 5000);
      2:       total_w = 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: total_w = $urandom();
    endcase
    total = total_w[FRAME_W-1:0];
    en_w = $urandom();
    en_w[0] = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0:       offset_w = 32'd0;
      1:       offset_w = 32'hFFFF_FFFF;
      default: offset_w = $urandom();
    endcase
    bpf_w = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 8) : $urandom_range(0, 15);
    cfg_all(total_w, pick_point(total), pick_point(total), en_w,
            pick_point(total), pick_point(total), offset_w, bpf_w);
  endtask

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return COUNT_W'($urandom_range(1, SLAG_MAX_BURST));
    if (sel < 93) return COUNT_W'($urandom_range(SLAG_MAX_BURST + 1, 31));
    return '0;
  endfunction

  // Seek targets cluster round the loop end, the loop start and the data end,
  // where the wrap and stop decisions happen.
  function automatic logic [SEEK_W-1:0] pick_seek();
    logic [FRAME_W-1:0] reg_end, lp_start, lp_end;
    int unsigned        back;
    tracker.resolve_region(reg_end, lp_start, lp_end);
    back = $urandom_range(0, 20);
    case ($urandom_range(0, 9))
      0:       return -SEEK_W'($urandom_range(1, 1000));
      1:       return $urandom();
      2:       return 32'(tracker.total_frames);
      3:       return 32'(tracker.total_frames) + $urandom_range(1, 8);
      4, 5:    return (lp_end > back) ? 32'(lp_end) - back : 32'd0;
      6:       return 32'(lp_start) + $urandom_range(0, 4);
      default: return $urandom_range(0, tracker.total_frames);
    endcase
  endfunction

  task automatic random_traffic(int items);
    int                 done;
    int unsigned        sel;
    logic [COUNT_W-1:0] cnt;
    logic [SEEK_W-1:0]  tgt;
    done = 0;
    while (done < items) begin
      sel = $urandom_range(0, 99);
      cnt = COUNT_W'($urandom());
      tgt = $urandom();
      if (sel < 4) begin
        wait_idle();
        continue;
      end
      if (sel < 62) send_req(REQ_FETCH, pick_count(), tgt);
      else if (sel < 82) send_req(REQ_SEEK, cnt, pick_seek());
      else if (sel < 93) send_req(REQ_RESTART, cnt, tgt);
      else send_req(REQ_ILLEGAL, cnt, tgt);
      done++;
    end
  endtask

  // Result side: check every accepted transaction, then choose the next ready.
  initial begin : result_sink
    int           stall;
    play_result_t got;
    stall = 0;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_res.valid && out_res.ready) begin
        got.frame_valid  = out_res.frame_valid;
        got.frame_index  = out_res.frame_index;
        got.byte_address = out_res.byte_address;
        got.wrapped      = out_res.wrapped;
        got.last         = out_res.last;
        tracker.check_frame(got);
      end
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        stall--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // Cycle guard: end the run if the traffic never drains.
  initial begin : watchdog
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    tracker  = new();
    no_idle  = 1'b0;
    req_held = 1'b0;
    cfg_held = 1'b0;
    rst_n              <= 1'b0;
    in_req.valid       <= 1'b0;
    in_req.req_type    <= REQ_FETCH;
    in_req.frame_count <= '0;
    in_req.seek_target <= '0;
    cfg_wr.valid       <= 1'b0;
    cfg_wr.index       <= CFG_TOTAL_FRAMES;
    cfg_wr.data        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: no data at all, so a fetch yields nothing and a seek clamps to 0.
    send_req(REQ_FETCH, 5'd1, 32'd0);
    send_req(REQ_SEEK, 5'd0, 32'd5);

    // Loop over 4..9 inside 20 frames, offset near the top so the address carries.
    cfg_all(32'd20, 32'd4, 32'd0, 32'd1, 32'd0, 32'd10, 32'hFFFF_FFF0, 32'd8);
    send_req(REQ_RESTART, 5'd0, 32'd0);
    send_req(REQ_FETCH, 5'd16, 32'hFFFF_FFFF);  // several wraps in one burst
    send_req(REQ_FETCH, 5'd0, 32'd0);           // zero count: no frame
    send_req(REQ_FETCH, 5'd31, 32'd0);          // count saturates at the burst size
    send_req(REQ_SEEK, 5'd31, -32'sd5);         // negative target clamps to 0
    send_req(REQ_SEEK, 5'd0, 32'd100);          // beyond the data: clamps to total
    send_req(REQ_FETCH, 5'd3, 32'd0);           // position past the loop end wraps
    send_req(REQ_ILLEGAL, 5'd16, 32'hA5A5_5A5A);
    send_req(REQ_SEEK, 5'd0, 32'h7FFF_FFFF);

    // No looping, trimmed to 12 frames, odd frame size: the fetch stops at the end.
    cfg_all(32'd20, 32'd4, 32'd12, 32'd0, 32'd0, 32'd10, 32'h0000_1000, 32'd15);
    send_req(REQ_SEEK, 5'd0, 32'd9);
    send_req(REQ_FETCH, 5'd16, 32'd0);
    send_req(REQ_FETCH, 5'd2, 32'd0);           // already at the end

    // Empty loop region: looping on but start equals end, so the burst stops.
    cfg_all(32'd20, 32'd4, 32'd12, 32'd1, 32'd6, 32'd6, 32'd0, 32'd0);
    send_req(REQ_SEEK, 5'd0, 32'd3);
    send_req(REQ_FETCH, 5'd8, 32'd0);

    // Largest data set, all-ones writes, widest address arithmetic.
    cfg_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF,
            32'hFFFF_FFFF);
    send_req(REQ_SEEK, 5'd0, 32'h7FFF_FFF8);
    send_req(REQ_FETCH, 5'd16, 32'h5555_5555);  // runs into the end and wraps to 0
    send_req(REQ_RESTART, 5'd31, 32'd0);
    send_req(REQ_SEEK, 5'd0, 32'h8000_0000);

    // Random phases, each under a fresh register setting; one runs without idling.
    for (int phase = 0; phase < PHASES; phase++) begin
      random_setting();
      no_idle = (phase == 3);
      random_traffic(PHASE_ITEMS);
    end
    no_idle = 1'b0;

    // Drain, let the clock run on for anything stray, then give the verdict.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
